// ===== hw/rtl/mzr_pkg.sv =====
// Package for the multislope ADC zero-corrected reading unit.
// Holds field widths, fixed constants, register indexes and shared types.
// No dependencies.
package mzr_pkg;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_ADDR_W-1:0] CFG_ADC_GAIN     = 4'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_ADC_OFFSET   = 4'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_RANGE_OFFSET = 4'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_RANGE_GAIN   = 4'd3;

  localparam int READING_W = 40;
  localparam int CNT_W     = 35;
  localparam int DIFF_W    = 36;
  localparam int S_W       = 60;
  localparam int SM_W      = 58;
  localparam int RMAG_W    = 42;

  // 1000 * 2^24 / 3477, rounded
  localparam logic [31:0] SCALE_Q24  = 32'd4825199;
  localparam logic [RMAG_W-1:0] OVER_LIMIT = 42'd11000000;

  typedef struct packed {
    logic        [15:0] adc_gain;
    logic signed [15:0] adc_offset;
    logic signed [31:0] range_offset;
    logic signed [31:0] range_gain;
  } cfg_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
  } mul_req_t;

endpackage

// ===== hw/rtl/mzr_if.sv =====
// Channel interfaces for the zero-corrected reading unit: frame in, reading out.
// Depends on nothing but the standard valid/ready handshake.
interface mzr_frame_if;
  logic        valid;
  logic        ready;
  logic [15:0] run_up_count;
  logic [11:0] total_count;
  logic        rundown_polarity;
  logic [15:0] rundown_count;

  modport source (output valid, run_up_count, total_count, rundown_polarity,
                  rundown_count, input ready);
  modport sink   (input valid, run_up_count, total_count, rundown_polarity,
                  rundown_count, output ready);
endinterface

interface mzr_result_if;
  logic               valid;
  logic               ready;
  logic signed [39:0] reading;
  logic               over_range;

  modport source (output valid, reading, over_range, input ready);
  modport sink   (input valid, reading, over_range, output ready);
endinterface

// ===== hw/rtl/multislope_adc_zero_corrected_reading_unit.sv =====
// Multislope ADC zero-corrected reading unit: sequencer around one shared multiplier.
// Depends on mzr_pkg, mzr_if, mzr_mul, mzr_cfg.
// Settling and zero frames: GAIN then CNT, then ready again; no transaction out.
// Measurement frame: result valid and ready again on leaving OUT, later while an earlier
// reading is stalled; its states follow the five passes through the shared multiplier.
// Synchronous reset clears phase, zero reference and output valid; config takes defaults.
module multislope_adc_zero_corrected_reading_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [mzr_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [mzr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  mzr_frame_if.sink                      frame,
  mzr_result_if.source                   result
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_GAIN = 4'd1;
  localparam logic [3:0] ST_CNT  = 4'd2;
  localparam logic [3:0] ST_DIFF = 4'd3;
  localparam logic [3:0] ST_K0   = 4'd4;
  localparam logic [3:0] ST_K1   = 4'd5;
  localparam logic [3:0] ST_K2   = 4'd6;
  localparam logic [3:0] ST_SOFF = 4'd7;
  localparam logic [3:0] ST_ABS  = 4'd8;
  localparam logic [3:0] ST_G0   = 4'd9;
  localparam logic [3:0] ST_G1   = 4'd10;
  localparam logic [3:0] ST_G2   = 4'd11;
  localparam logic [3:0] ST_OUT  = 4'd12;

  localparam int CNT_W  = mzr_pkg::CNT_W;
  localparam int DIFF_W = mzr_pkg::DIFF_W;
  localparam int S_W    = mzr_pkg::S_W;
  localparam int SM_W   = mzr_pkg::SM_W;
  localparam int RMAG_W = mzr_pkg::RMAG_W;
  localparam int RD_W   = mzr_pkg::READING_W;

  localparam logic [RMAG_W-1:0] POS_MAX = RMAG_W'((64'd1 << (RD_W - 1)) - 64'd1);
  localparam logic [RMAG_W-1:0] NEG_MAX = RMAG_W'(64'd1 << (RD_W - 1));

  mzr_pkg::cfg_t     cfg;
  mzr_pkg::mul_req_t mul_req;
  logic [63:0]       prod;

  logic [3:0]  state;
  logic [1:0]  phase;
  logic [1:0]  ph_q;
  logic [15:0] up_q;
  logic [11:0] tot_q;
  logic        pol_q;
  logic [15:0] rd_q;

  logic signed [CNT_W-1:0]  counts_r;
  logic signed [CNT_W-1:0]  zero_counts;
  logic [DIFF_W-1:0]        dm;
  logic                     dneg;
  logic [63:0]              acc;
  logic signed [S_W-1:0]    s_r;
  logic [SM_W-1:0]          sm;
  logic                     sneg;
  logic [RMAG_W-1:0]        rmag;

  logic                     out_valid;
  logic signed [RD_W-1:0]   out_reading;
  logic                     out_over;

  // combinational terms
  logic [11:0]              half;
  logic signed [17:0]       up_diff;
  logic                     up_neg;
  logic [15:0]              up_mag;
  logic signed [17:0]       rd_term;
  logic signed [CNT_W-1:0]  c_val;
  logic signed [CNT_W-1:0]  counts_next;
  logic signed [DIFF_W-1:0] diff;
  logic signed [S_W-1:0]    off_sh;
  logic signed [S_W-1:0]    p_ext;
  logic [31:0]              gm;
  logic                     gneg;
  logic [SM_W-1:0]          t_sum;
  logic                     rneg;
  logic [RMAG_W-1:0]        rsat;
  logic                     out_free;
  logic                     accept;

  mzr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  mzr_mul u_mul (
    .clk  (clk),
    .req  (mul_req),
    .prod (prod)
  );

  assign accept       = frame.valid && frame.ready;
  assign frame.ready  = (state == ST_IDLE);
  assign out_free     = !out_valid || result.ready;

  assign half    = 12'((13'(tot_q) + 13'd1) >> 1);
  assign up_diff = $signed({6'd0, half}) - $signed({2'd0, up_q});
  assign up_neg  = up_diff[17];
  assign up_mag  = up_neg ? 16'(-up_diff) : up_diff[15:0];
  assign rd_term = pol_q ? ($signed({2'd0, rd_q}) + {{2{cfg.adc_offset[15]}}, cfg.adc_offset})
                         : -$signed({2'd0, rd_q});
  assign c_val   = up_neg ? -$signed({3'd0, prod[31:0]}) : $signed({3'd0, prod[31:0]});
  assign counts_next = c_val - {{(CNT_W-18){rd_term[17]}}, rd_term};
  assign diff    = {counts_r[CNT_W-1], counts_r} - {zero_counts[CNT_W-1], zero_counts};

  assign off_sh  = {{(S_W-56){cfg.range_offset[31]}}, cfg.range_offset, 24'd0};
  assign p_ext   = $signed({2'd0, acc[SM_W-1:0]});

  assign gneg    = cfg.range_gain[31];
  assign gm      = gneg ? 32'(-cfg.range_gain) : cfg.range_gain;
  assign t_sum   = SM_W'(prod) + SM_W'(acc[63:32]);

  assign rneg    = (sneg != gneg) && (rmag != '0);
  always_comb begin
    if (rneg) begin
      rsat = (rmag > NEG_MAX) ? NEG_MAX : rmag;
    end else begin
      rsat = (rmag > POS_MAX) ? POS_MAX : rmag;
    end
  end

  always_comb begin
    mul_req = '0;
    case (state)
      ST_GAIN: begin
        mul_req.a = 32'(up_mag);
        mul_req.b = 32'(cfg.adc_gain);
      end
      ST_K0: begin
        mul_req.a = dm[31:0];
        mul_req.b = mzr_pkg::SCALE_Q24;
      end
      ST_K1: begin
        mul_req.a = 32'(dm[DIFF_W-1:32]);
        mul_req.b = mzr_pkg::SCALE_Q24;
      end
      ST_G0: begin
        mul_req.a = sm[31:0];
        mul_req.b = gm;
      end
      ST_G1: begin
        mul_req.a = 32'(sm[SM_W-1:32]);
        mul_req.b = gm;
      end
      default: mul_req = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      phase       <= '0;
      zero_counts <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && result.ready && (state != ST_OUT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            phase <= phase + 2'd1;
            state <= ST_GAIN;
          end
        end
        ST_GAIN: state <= ST_CNT;
        ST_CNT: begin
          if (ph_q == 2'd1) begin
            zero_counts <= counts_next;
          end
          state <= (ph_q == 2'd3) ? ST_DIFF : ST_IDLE;
        end
        ST_DIFF: state <= ST_K0;
        ST_K0:   state <= ST_K1;
        ST_K1:   state <= ST_K2;
        ST_K2:   state <= ST_SOFF;
        ST_SOFF: state <= ST_ABS;
        ST_ABS:  state <= ST_G0;
        ST_G0:   state <= ST_G1;
        ST_G1:   state <= ST_G2;
        ST_G2:   state <= ST_OUT;
        ST_OUT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ph_q  <= phase;
      up_q  <= frame.run_up_count;
      tot_q <= frame.total_count;
      pol_q <= frame.rundown_polarity;
      rd_q  <= frame.rundown_count;
    end
    case (state)
      ST_CNT:  counts_r <= counts_next;
      ST_DIFF: begin
        dneg <= diff[DIFF_W-1];
        dm   <= diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
      end
      ST_K1:   acc <= prod;
      ST_K2:   acc <= acc + {prod[31:0], 32'd0};
      // s = range_offset * 2^24 - diff * scale
      ST_SOFF: s_r <= dneg ? (off_sh + p_ext) : (off_sh - p_ext);
      ST_ABS: begin
        sneg <= s_r[S_W-1];
        sm   <= s_r[S_W-1] ? SM_W'(-s_r) : SM_W'(s_r);
      end
      ST_G1:   acc <= prod + (64'd1 << 47);
      ST_G2:   rmag <= t_sum[SM_W-1:16];
      ST_OUT: begin
        if (out_free) begin
          out_over    <= (rmag > mzr_pkg::OVER_LIMIT);
          out_reading <= rneg ? -$signed(RD_W'(rsat)) : $signed(RD_W'(rsat));
        end
      end
      default: ;
    endcase
  end

  assign result.valid      = out_valid;
  assign result.reading    = out_reading;
  assign result.over_range = out_over;

endmodule

// ===== hw/rtl/mzr_mul.sv =====
// Shared 32x32 unsigned multiplier with a registered product.
// Depends on mzr_pkg (mul_req_t).
module mzr_mul (
  input  logic              clk,
  input  mzr_pkg::mul_req_t req,
  output logic [63:0]       prod
);

  always_ff @(posedge clk) begin
    prod <= 64'(req.a) * 64'(req.b);
  end

endmodule

// ===== hw/rtl/mzr_cfg.sv =====
// Configuration register file: ADC gain/offset and range calibration.
// Depends on mzr_pkg (cfg_t, register indexes).
module mzr_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [mzr_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [mzr_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output mzr_pkg::cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.adc_gain     <= 16'd1;
      cfg.adc_offset   <= '0;
      cfg.range_offset <= '0;
      cfg.range_gain   <= 32'sh0100_0000;
    end else if (cfg_we) begin
      case (cfg_addr)
        mzr_pkg::CFG_ADC_GAIN:     cfg.adc_gain     <= cfg_wdata[15:0];
        mzr_pkg::CFG_ADC_OFFSET:   cfg.adc_offset   <= $signed(cfg_wdata[15:0]);
        mzr_pkg::CFG_RANGE_OFFSET: cfg.range_offset <= $signed(cfg_wdata);
        mzr_pkg::CFG_RANGE_GAIN:   cfg.range_gain   <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/mzr_chk.sv =====
// Port-level checker for the zero-corrected reading unit, bound to the top level.
// Depends on the top level's ports only.
module mzr_chk (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [39:0] reading,
  input logic               over_range
);

  // stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(reading) && $stable(over_range))
    else $error("result changed while stalled");

  // flag agrees with magnitude
  a_over_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid && (reading > 40'sd11000000 || reading < -40'sd11000000) |-> over_range)
    else $error("over_range missing for large reading");

  a_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && !over_range |-> reading <= 40'sd11000000 && reading >= -40'sd11000000)
    else $error("over_range set for in-range reading");

  // a reading never appears right after a frame transaction
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_valid && in_ready, 1) && !$past(in_valid && in_ready, 2))
    else $error("result too soon after frame");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind multislope_adc_zero_corrected_reading_unit mzr_chk u_mzr_chk (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (frame.valid),
  .in_ready   (frame.ready),
  .out_valid  (result.valid),
  .out_ready  (result.ready),
  .reading    (result.reading),
  .over_range (result.over_range)
);

// ===== verif/mzr_tb_pkg.sv =====
`timescale 1ns / 100ps
// Scoreboard for the zero-corrected reading unit: frame and reading types,
// a bit-accurate predictor of the reading, and the queue of pending readings.
// Depends on mzr_pkg.
package mzr_tb_pkg;

  typedef struct packed {
    logic [15:0] run_up_count;
    logic [11:0] total_count;
    logic        rundown_polarity;
    logic [15:0] rundown_count;
  } frame_t;

  typedef struct packed {
    logic signed [39:0] reading;
    logic               over_range;
  } reading_t;

  typedef enum logic [1:0] {
    PH_SETTLE_A,
    PH_ZERO,
    PH_SETTLE_B,
    PH_MEASURE
  } frame_phase_e;

  class reading_scoreboard;
    mzr_pkg::cfg_t regs;
    frame_phase_e  frame_phase;
    longint        zero_ref;
    reading_t      expected_readings[$];
    int            errors;

    function new();
      regs.adc_gain     = 16'd1;
      regs.adc_offset   = 16'sd0;
      regs.range_offset = 32'sd0;
      regs.range_gain   = 32'sh0100_0000;
      frame_phase       = PH_SETTLE_A;
      zero_ref          = 0;
      errors            = 0;
    endfunction

    function void write_reg(logic [mzr_pkg::CFG_ADDR_W-1:0] addr,
                            logic [mzr_pkg::CFG_DATA_W-1:0] data);
      case (addr)
        mzr_pkg::CFG_ADC_GAIN:     regs.adc_gain     = data[15:0];
        mzr_pkg::CFG_ADC_OFFSET:   regs.adc_offset   = data[15:0];
        mzr_pkg::CFG_RANGE_OFFSET: regs.range_offset = data;
        mzr_pkg::CFG_RANGE_GAIN:   regs.range_gain   = data;
        default: ;
      endcase
    endfunction

    function longint raw_counts(frame_t f);
      longint tot, up, rd, gain, ofs, r;
      tot  = f.total_count;
      up   = f.run_up_count;
      rd   = f.rundown_count;
      gain = regs.adc_gain;
      ofs  = $signed(regs.adc_offset);
      r    = f.rundown_polarity ? rd + ofs : -rd;
      return (((tot + 1) >>> 1) - up) * gain - r;
    endfunction

    function reading_t calibrate(longint diff);
      longint       k, co, g, s;
      logic [63:0]  sm, gm;
      logic [127:0] prod;
      logic [79:0]  mag;
      logic         sneg, gneg, neg;
      reading_t     res;
      k    = mzr_pkg::SCALE_Q24;
      co   = $signed(regs.range_offset);
      g    = $signed(regs.range_gain);
      s    = -(diff * k) + (co <<< 24);
      sneg = s < 0;
      gneg = g < 0;
      sm   = sneg ? -s : s;
      gm   = gneg ? -g : g;
      // Q.24 times Q8.24, rounded once on the magnitude, halves away from zero
      prod = {64'd0, sm} * {64'd0, gm} + (128'd1 << 47);
      mag  = prod[127:48];
      res.over_range = mag > mzr_pkg::OVER_LIMIT;
      neg  = (sneg != gneg) && (mag != 80'd0);
      if (neg) begin
        if (mag > (80'd1 << 39)) mag = 80'd1 << 39;
        mag = -mag;
      end else if (mag > (80'd1 << 39) - 80'd1) begin
        mag = (80'd1 << 39) - 80'd1;
      end
      res.reading = mag[39:0];
      return res;
    endfunction

    function void note_frame(frame_t f);
      longint counts;
      counts = raw_counts(f);
      case (frame_phase)
        PH_ZERO:    zero_ref = counts;
        PH_MEASURE: expected_readings.push_back(calibrate(counts - zero_ref));
        default: ;
      endcase
      frame_phase = frame_phase_e'(frame_phase + 2'd1);
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_reading(reading_t got);
      reading_t exp;
      if (expected_readings.size() == 0) begin
        report($sformatf("reading %0d with none expected", got.reading));
      end else begin
        exp = expected_readings.pop_front();
        if (got.reading !== exp.reading)
          report($sformatf("reading %0d, expected %0d", got.reading, exp.reading));
        if (got.over_range !== exp.over_range)
          report($sformatf("over_range %b, expected %b (reading %0d)",
                           got.over_range, exp.over_range, exp.reading));
      end
    endtask

    function int pending();
      return expected_readings.size();
    endfunction
  endclass

endpackage

// ===== verif/multislope_adc_zero_corrected_reading_unit_tb.sv =====
`timescale 1ns / 100ps
// Top-level testbench for the zero-corrected reading unit: drives frames and
// register writes, stalls both channels at random, checks readings in order.
// Depends on mzr_pkg, mzr_if, mzr_tb_pkg and the unit itself.
module multislope_adc_zero_corrected_reading_unit_tb;

  localparam int SETTLE_CYCLES = 20;
  localparam int END_CYCLES    = 40;
  localparam int HOLD_CYCLES   = 400;
  localparam int IDLE_LIMIT    = 3000;
  localparam int RAND_SETTINGS = 10;
  localparam int SETTING_ITEMS = 55;

  localparam mzr_tb_pkg::frame_t F_MIN  = '{16'h0000, 12'h000, 1'b0, 16'h0000};
  localparam mzr_tb_pkg::frame_t F_HIGH = '{16'h0000, 12'hFFF, 1'b0, 16'hFFFF};
  localparam mzr_tb_pkg::frame_t F_LOW  = '{16'hFFFF, 12'h000, 1'b1, 16'hFFFF};
  localparam mzr_tb_pkg::frame_t F_ALL1 = '{16'hFFFF, 12'hFFF, 1'b1, 16'hFFFF};

  logic                           clk;
  logic                           rst = 1'b1;
  logic                           cfg_we;
  logic [mzr_pkg::CFG_ADDR_W-1:0] cfg_addr;
  logic [mzr_pkg::CFG_DATA_W-1:0] cfg_wdata;

  mzr_frame_if  frame_ch ();
  mzr_result_if result_ch ();

  mzr_tb_pkg::reading_scoreboard sb;
  bit calm;
  bit rx_hold_req;
  int rx_stall;
  int idle_cycles;

  multislope_adc_zero_corrected_reading_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .frame     (frame_ch.sink),
    .result    (result_ch.source)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] rand16();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  function automatic mzr_tb_pkg::frame_t rand_frame();
    mzr_tb_pkg::frame_t f;
    int                 r;
    r = $urandom_range(9);
    f.run_up_count     = rand16();
    f.total_count      = (r == 0) ? 12'h000 : (r == 1) ? 12'hFFF : 12'($urandom);
    f.rundown_polarity = 1'($urandom);
    f.rundown_count    = rand16();
    return f;
  endfunction

  function automatic mzr_pkg::cfg_t rand_regs();
    mzr_pkg::cfg_t c;
    int            r;
    r = $urandom_range(9);
    c.adc_gain = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF :
                 (r < 5) ? 16'($urandom_range(1, 64)) : 16'($urandom);
    r = $urandom_range(9);
    c.adc_offset = (r == 0) ? 16'h8000 : (r == 1) ? 16'h7FFF : 16'($urandom);
    r = $urandom_range(9);
    c.range_offset = (r == 0) ? 32'h8000_0000 : (r == 1) ? 32'h7FFF_FFFF :
                     (r < 6) ? 32'(int'($urandom_range(0, 2000)) - 1000) : $urandom;
    r = $urandom_range(9);
    c.range_gain = (r == 0) ? 32'h8000_0000 : (r == 1) ? 32'h7FFF_FFFF :
                   (r < 7) ? 32'(32'sh0100_0000 + int'($urandom_range(0, 1 << 20)) - (1 << 19))
                           : $urandom;
    return c;
  endfunction

  task automatic put_reg(logic [mzr_pkg::CFG_ADDR_W-1:0] addr,
                         logic [mzr_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    sb.write_reg(addr, data);
  endtask

  task automatic load_regs(mzr_pkg::cfg_t c);
    logic [mzr_pkg::CFG_DATA_W-1:0] junk;
    logic [mzr_pkg::CFG_ADDR_W-1:0] spare;
    junk  = $urandom;
    spare = mzr_pkg::CFG_ADDR_W'($urandom_range(mzr_pkg::CFG_RANGE_GAIN + 1,
                                                 2 ** mzr_pkg::CFG_ADDR_W - 1));
    put_reg(mzr_pkg::CFG_ADC_GAIN, {junk[31:16], c.adc_gain});
    put_reg(mzr_pkg::CFG_ADC_OFFSET, {junk[15:0], c.adc_offset});
    put_reg(mzr_pkg::CFG_RANGE_OFFSET, c.range_offset);
    put_reg(mzr_pkg::CFG_RANGE_GAIN, c.range_gain);
    put_reg(spare, $urandom);
    cfg_we <= 1'b0;
  endtask

  task automatic send_frame(mzr_tb_pkg::frame_t f, int gap);
    if (gap > 0) begin
      frame_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    frame_ch.valid            <= 1'b1;
    frame_ch.run_up_count     <= f.run_up_count;
    frame_ch.total_count      <= f.total_count;
    frame_ch.rundown_polarity <= f.rundown_polarity;
    frame_ch.rundown_count    <= f.rundown_count;
    @(posedge clk);
    while (!frame_ch.ready) @(posedge clk);
  endtask

  task automatic send_block(mzr_tb_pkg::frame_t a, mzr_tb_pkg::frame_t b,
                            mzr_tb_pkg::frame_t c, mzr_tb_pkg::frame_t d);
    send_frame(a, pick_gap());
    send_frame(b, pick_gap());
    send_frame(c, pick_gap());
    send_frame(d, pick_gap());
  endtask

  task automatic wait_idle(int extra);
    frame_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  initial begin
    frame_ch.valid            = 1'b0;
    frame_ch.run_up_count     = '0;
    frame_ch.total_count      = '0;
    frame_ch.rundown_polarity = 1'b0;
    frame_ch.rundown_count    = '0;
    result_ch.ready           = 1'b0;
    cfg_we                    = 1'b0;
    cfg_addr                  = '0;
    cfg_wdata                 = '0;
  end

  // result side: random back-pressure, long hold on request
  always @(posedge clk) begin
    if (rx_hold_req) begin
      rx_stall    = HOLD_CYCLES;
      rx_hold_req = 1'b0;
    end
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else if (rx_stall > 0) begin
      result_ch.ready <= 1'b0;
      rx_stall--;
    end else begin
      result_ch.ready <= 1'b1;
      if (!calm) rx_stall = pick_gap();
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (frame_ch.valid && frame_ch.ready)
        sb.note_frame('{frame_ch.run_up_count, frame_ch.total_count,
                        frame_ch.rundown_polarity, frame_ch.rundown_count});
      if (result_ch.valid && result_ch.ready)
        sb.check_reading('{result_ch.reading, result_ch.over_range});
      if ((frame_ch.valid && frame_ch.ready) || (result_ch.valid && result_ch.ready) || cfg_we)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    sb = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset settings, count extremes in both orders
    send_block(F_MIN, F_HIGH, F_ALL1, F_LOW);
    send_block(F_ALL1, F_LOW, F_MIN, F_HIGH);
    wait_idle(SETTLE_CYCLES);
    load_regs('{16'hFFFF, 16'h7FFF, 32'h7FFF_FFFF, 32'h8000_0000});
    send_block(F_MIN, F_HIGH, F_MIN, F_LOW);
    wait_idle(SETTLE_CYCLES);
    load_regs('{16'hFFFF, 16'h8000, 32'h8000_0000, 32'h7FFF_FFFF});
    send_block(F_MIN, F_LOW, F_ALL1, F_HIGH);
    // zero difference, half gain: +2.5 and -2.5 round away from zero
    wait_idle(SETTLE_CYCLES);
    load_regs('{16'h0000, 16'h8000, 32'sd5, 32'h0080_0000});
    send_block(F_MIN, F_ALL1, F_HIGH, F_ALL1);
    wait_idle(SETTLE_CYCLES);
    load_regs('{16'h0001, 16'h0000, -32'sd5, 32'h0080_0000});
    send_block(F_MIN, F_MIN, F_MIN, F_MIN);

    for (int s = 0; s < RAND_SETTINGS; s++) begin
      wait_idle(SETTLE_CYCLES);
      load_regs(rand_regs());
      calm = (s == 2) || (s == 7);
      if (s == 4) rx_hold_req = 1'b1;
      for (int i = 0; i < SETTING_ITEMS; i++)
        send_frame(rand_frame(), calm ? 0 : pick_gap());
    end

    wait_idle(END_CYCLES);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d readings never arrived", sb.pending()));
    if (sb.errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/mzr_pkg.sv
hw/rtl/mzr_if.sv
hw/rtl/mzr_mul.sv
hw/rtl/mzr_cfg.sv
hw/rtl/multislope_adc_zero_corrected_reading_unit.sv
hw/rtl/mzr_chk.sv
verif/mzr_tb_pkg.sv
verif/multislope_adc_zero_corrected_reading_unit_tb.sv
